### design/nlws_pkg.sv
// ----------------------------------------------------------------------------
// nlws_pkg: shared types and constants for the noise level window statistics
// Holds the controller/datapath command and status structures, the
// configuration register indexes and the fixed constants of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package nlws_pkg;

  // Sample range and fixed levels.
  localparam int unsigned LEVEL_W        = 12;
  localparam int unsigned DUTY_W         = 7;
  localparam int unsigned QUO_BITS       = 12;
  localparam int unsigned MAX12          = 4095;
  localparam int unsigned MIN_RESET      = 1000;
  localparam int unsigned LEVEL_TOP      = 99;
  localparam int unsigned LEVEL_RESET    = 50;
  localparam int unsigned MIN_COUNT_GATE = 5;
  localparam int unsigned SECOND_MS      = 1000;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  // Register widths and reset values.
  localparam int unsigned LEGAL_PER_W = 16;
  localparam int unsigned DUTY_PER_W  = 22;
  localparam logic [LEGAL_PER_W-1:0] LEGAL_PERIOD_RST = 16'd5000;
  localparam logic [DUTY_PER_W-1:0]  DUTY_PERIOD_RST  = 22'd60000;
  localparam logic [LEVEL_W-1:0]     SLEEP_MARGIN_RST = 12'd30;
  localparam logic [LEVEL_W-1:0]     INITIAL_LOW_RST  = 12'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEGAL_PERIOD = 2'd0,
    CFG_DUTY_PERIOD  = 2'd1,
    CFG_SLEEP_MARGIN = 2'd2,
    CFG_INITIAL_LOW  = 2'd3
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input request
    logic pre;       // per-sample updates and window checks
    logic l_start;   // start the legal-window division
    logic l_load;    // store the legal average
    logic d_start;   // start the duty-window division
    logic d_load;    // store the duty average
    logic d_fin;     // duty window close-out and duty level step
    logic out_load;  // load the result register
  } nlws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic legal_hit;  // legal window ends with this sample
    logic duty_hit;   // duty window ends with this sample
    logic duty_end;   // registered duty window end flag
    logic duty_zero;  // duty window holds no counted samples
    logic div_done;   // divider finished
    logic out_free;   // result register can take a new result
  } nlws_sts_t;

endpackage

`default_nettype wire

### design/nlws_div.sv
// ----------------------------------------------------------------------------
// nlws_div: clipped restoring divider
// Divides a sum by a count and clips the quotient to twelve bits. A clip check
// comes first; unless it clips, twelve steps settle one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module nlws_div #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned SUM_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [SUM_BITS-1:0]                dividend,
  input  wire logic [COUNT_BITS-1:0]              divisor,
  output logic                                    done,
  output logic [nlws_pkg::QUO_BITS-1:0]           quotient
);
  import nlws_pkg::*;

  localparam int unsigned DSH_W = COUNT_BITS + QUO_BITS;
  localparam int unsigned W     = (SUM_BITS > DSH_W) ? SUM_BITS : DSH_W;
  localparam int unsigned CNT_W = $clog2(QUO_BITS);

  logic              busy_r;
  logic              first_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [W-1:0]      rem_r;
  logic [W-1:0]      dsh_r;
  logic [QUO_BITS-1:0] quo_r;

  logic              fits;

  // The shifted divisor fits into the remainder.
  assign fits = (rem_r >= dsh_r);

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
      end else if (busy_r && first_r) begin
        first_r <= 1'b0;
        cnt_r   <= CNT_W'(QUO_BITS - 1);
        if (fits) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Remainder, shifted divisor and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= W'(dividend);
      dsh_r <= W'({divisor, {QUO_BITS{1'b0}}});
    end else if (busy_r && first_r) begin
      if (fits) begin
        quo_r <= QUO_BITS'(MAX12);
      end
      dsh_r <= dsh_r >> 1;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[QUO_BITS-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### design/nlws_dp.sv
// ----------------------------------------------------------------------------
// nlws_dp: datapath of the noise level window statistics
// Holds the configuration registers, the window state, the divider and the
// result register, and carries out the steps that the controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nlws_dp #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned SUM_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire nlws_pkg::nlws_cmd_t                cmd,
  output nlws_pkg::nlws_sts_t                     sts,
  input  wire logic                               cfg_we,
  input  wire logic [nlws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nlws_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [15:0]                        in_sample,
  input  wire logic [31:0]                        in_now_ms,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic                                    out_accepted,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_noise_average,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_legal_average,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_legal_maximum,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_peak_level,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_minimum_level,
  output logic [nlws_pkg::LEVEL_W-1:0]            out_low_level,
  output logic [nlws_pkg::DUTY_W-1:0]             out_duty_level,
  output logic                                    out_legal_window_end,
  output logic                                    out_duty_window_end
);
  import nlws_pkg::*;

  // Configuration registers.
  logic [LEGAL_PER_W-1:0] legal_period_r;
  logic [DUTY_PER_W-1:0]  duty_period_r;
  logic [LEVEL_W-1:0]     sleep_margin_r;

  // Latched input request.
  logic [15:0]            smp_r;
  logic [31:0]            now_r;

  // Window state.
  logic [LEVEL_W-1:0]     floor_r;
  logic [31:0]            second_mark_r;
  logic [31:0]            duty_mark_r;
  logic [31:0]            legal_mark_r;
  logic [SUM_BITS-1:0]    duty_sum_r;
  logic [COUNT_BITS-1:0]  duty_count_r;
  logic [SUM_BITS-1:0]    legal_sum_r;
  logic [COUNT_BITS-1:0]  legal_count_r;
  logic [LEVEL_W-1:0]     avg_now_r;
  logic [LEVEL_W-1:0]     avg_prev_r;
  logic [LEVEL_W-1:0]     legal_avg_r;
  logic [LEVEL_W-1:0]     legal_max_r;
  logic [LEVEL_W-1:0]     peak_r;
  logic [LEVEL_W-1:0]     min_r;
  logic [DUTY_W-1:0]      level_r;
  logic                   step_down_r;
  logic                   legal_end_r;
  logic                   duty_end_r;
  logic                   out_valid_r;

  // Per-sample combinational values.
  logic                   ok;
  logic [LEVEL_W-1:0]     s12;
  logic                   sec_hit;
  logic                   legal_hit;
  logic                   duty_hit;
  logic [SUM_BITS:0]      duty_sum_wide;
  logic [SUM_BITS:0]      legal_sum_wide;
  logic [SUM_BITS-1:0]    duty_sum_sat;
  logic [SUM_BITS-1:0]    legal_sum_sat;
  logic [COUNT_BITS-1:0]  duty_count_inc;
  logic [COUNT_BITS-1:0]  legal_count_inc;
  logic [COUNT_BITS-1:0]  duty_count_pre;

  // Duty window close-out values.
  logic                   sd_nxt;
  logic [LEVEL_W-1:0]     floor_fin;
  logic [DUTY_W-1:0]      level_step;
  logic [LEVEL_W:0]       quiet;
  logic                   both_quiet;
  logic [DUTY_W-1:0]      level_nxt;

  // Divider.
  logic                   div_start;
  logic [SUM_BITS-1:0]    div_dividend;
  logic [COUNT_BITS-1:0]  div_divisor;
  logic                   div_done;
  logic [QUO_BITS-1:0]    div_quo;

  // Range check and window timing of the latched sample.
  assign ok        = (smp_r[15:LEVEL_W] == '0);
  assign s12       = smp_r[LEVEL_W-1:0];
  assign sec_hit   = ((now_r - second_mark_r) > 32'(SECOND_MS));
  assign legal_hit = ok && ((now_r - legal_mark_r) > 32'(legal_period_r));
  assign duty_hit  = ok && ((now_r - duty_mark_r) > 32'(duty_period_r));

  // Saturating sums and counts.
  assign duty_sum_wide  = {1'b0, duty_sum_r} + (SUM_BITS+1)'(s12);
  assign legal_sum_wide = {1'b0, legal_sum_r} + (SUM_BITS+1)'(s12);
  assign duty_sum_sat   = duty_sum_wide[SUM_BITS] ? '1 : duty_sum_wide[SUM_BITS-1:0];
  assign legal_sum_sat  = legal_sum_wide[SUM_BITS] ? '1 : legal_sum_wide[SUM_BITS-1:0];
  assign duty_count_inc  = (&duty_count_r) ? duty_count_r : duty_count_r + 1'b1;
  assign legal_count_inc = (&legal_count_r) ? legal_count_r : legal_count_r + 1'b1;
  assign duty_count_pre  = sec_hit ? duty_count_inc : duty_count_r;

  // Duty level step: direction turns at the ends, and the level is held
  // when both the current and the previous averages are quiet.
  always_comb begin
    sd_nxt    = step_down_r;
    floor_fin = floor_r;
    if (level_r > DUTY_W'(LEVEL_TOP)) begin
      sd_nxt = 1'b1;
    end else if (level_r == '0) begin
      sd_nxt    = 1'b0;
      floor_fin = min_r;
    end
    level_step = sd_nxt ? level_r - 1'b1 : level_r + 1'b1;
    quiet      = {1'b0, floor_fin} + {1'b0, sleep_margin_r};
    both_quiet = ({1'b0, avg_now_r} < quiet) && ({1'b0, avg_prev_r} < quiet);
    level_nxt  = both_quiet ? level_r : level_step;
  end

  // Divider operands come from whichever window is being closed.
  assign div_start    = cmd.l_start || cmd.d_start;
  assign div_dividend = cmd.d_start ? duty_sum_r : legal_sum_r;
  assign div_divisor  = cmd.d_start ? duty_count_r : legal_count_r;

  nlws_div #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Input request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r <= in_sample;
      now_r <= in_now_ms;
    end
  end

  // Window state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      legal_period_r <= LEGAL_PERIOD_RST;
      duty_period_r  <= DUTY_PERIOD_RST;
      sleep_margin_r <= SLEEP_MARGIN_RST;
      floor_r        <= INITIAL_LOW_RST;
      avg_now_r      <= INITIAL_LOW_RST;
      avg_prev_r     <= INITIAL_LOW_RST;
      legal_avg_r    <= INITIAL_LOW_RST;
      legal_max_r    <= INITIAL_LOW_RST;
      second_mark_r  <= '0;
      duty_mark_r    <= '0;
      legal_mark_r   <= '0;
      duty_sum_r     <= '0;
      duty_count_r   <= '0;
      legal_sum_r    <= '0;
      legal_count_r  <= '0;
      peak_r         <= '0;
      min_r          <= LEVEL_W'(MIN_RESET);
      level_r        <= DUTY_W'(LEVEL_RESET);
      step_down_r    <= 1'b0;
      legal_end_r    <= 1'b0;
      duty_end_r     <= 1'b0;
    end else begin
      // Per-sample updates.
      if (cmd.pre) begin
        legal_end_r <= legal_hit;
        duty_end_r  <= duty_hit;
        if (ok) begin
          if (s12 < floor_r) begin
            floor_r <= s12;
          end
          if (sec_hit) begin
            duty_sum_r    <= duty_sum_sat;
            duty_count_r  <= duty_count_inc;
            second_mark_r <= now_r;
          end
          legal_sum_r   <= legal_sum_sat;
          legal_count_r <= legal_count_inc;
          if (s12 > peak_r) begin
            peak_r <= s12;
          end
          if ((s12 < min_r) && (duty_count_pre > COUNT_BITS'(MIN_COUNT_GATE))) begin
            min_r <= s12;
          end
        end
      end

      // Legal window close: operands go to the divider, the window restarts.
      if (cmd.l_start) begin
        legal_sum_r   <= '0;
        legal_count_r <= '0;
        legal_mark_r  <= now_r;
      end

      if (cmd.l_load) begin
        legal_avg_r <= div_quo;
        if (div_quo > legal_max_r) begin
          legal_max_r <= div_quo;
        end
      end

      if (cmd.d_load) begin
        avg_now_r <= div_quo;
      end

      // Duty window close-out.
      if (cmd.d_fin) begin
        step_down_r  <= sd_nxt;
        floor_r      <= floor_fin;
        level_r      <= level_nxt;
        peak_r       <= '0;
        min_r        <= LEVEL_W'(MIN_RESET);
        duty_sum_r   <= '0;
        duty_count_r <= '0;
        legal_max_r  <= '0;
        avg_prev_r   <= avg_now_r;
        legal_mark_r <= now_r;
        duty_mark_r  <= now_r;
      end

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEGAL_PERIOD: legal_period_r <= cfg_wdata[LEGAL_PER_W-1:0];
          CFG_DUTY_PERIOD:  duty_period_r  <= cfg_wdata[DUTY_PER_W-1:0];
          CFG_SLEEP_MARGIN: sleep_margin_r <= cfg_wdata[LEVEL_W-1:0];
          CFG_INITIAL_LOW: begin
            floor_r       <= cfg_wdata[LEVEL_W-1:0];
            avg_now_r     <= cfg_wdata[LEVEL_W-1:0];
            avg_prev_r    <= cfg_wdata[LEVEL_W-1:0];
            legal_avg_r   <= cfg_wdata[LEVEL_W-1:0];
            legal_max_r   <= cfg_wdata[LEVEL_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted         <= ok;
      out_noise_average    <= avg_now_r;
      out_legal_average    <= legal_avg_r;
      out_legal_maximum    <= legal_max_r;
      out_peak_level       <= peak_r;
      out_minimum_level    <= min_r;
      out_low_level        <= floor_r;
      out_duty_level       <= level_r;
      out_legal_window_end <= legal_end_r;
      out_duty_window_end  <= duty_end_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status towards the controller.
  always_comb begin
    sts.legal_hit = legal_hit;
    sts.duty_hit  = duty_hit;
    sts.duty_end  = duty_end_r;
    sts.duty_zero = (duty_count_r == '0);
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

### design/nlws_ctrl.sv
// ----------------------------------------------------------------------------
// nlws_ctrl: controller of the noise level window statistics
// Steps one request through its per-sample update, any window divisions and
// duty close-out that fall due, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nlws_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire nlws_pkg::nlws_sts_t  sts,
  output nlws_pkg::nlws_cmd_t       cmd
);
  import nlws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_LSTART,
    S_LWAIT,
    S_DSTART,
    S_DWAIT,
    S_DFIN,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        if (sts.legal_hit) begin
          state_nxt = S_LSTART;
        end else if (sts.duty_hit) begin
          state_nxt = S_DSTART;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_LSTART: begin
        cmd.l_start = 1'b1;
        state_nxt   = S_LWAIT;
      end
      S_LWAIT: begin
        if (sts.div_done) begin
          cmd.l_load = 1'b1;
          state_nxt  = sts.duty_end ? S_DSTART : S_OUT;
        end
      end
      S_DSTART: begin
        // An empty duty window keeps the old average.
        if (sts.duty_zero) begin
          state_nxt = S_DFIN;
        end else begin
          cmd.d_start = 1'b1;
          state_nxt   = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.d_load = 1'b1;
          state_nxt  = S_DFIN;
        end
      end
      S_DFIN: begin
        cmd.d_fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

### design/noise_level_window_stats.sv
// ----------------------------------------------------------------------------
// noise_level_window_stats: windowed statistics of a raw noise level stream
// Each input request carries a raw sample and a millisecond timestamp; each
// gives one result request with the current averages, levels and flags.
//
// Input channel in_valid/in_ready carries in_sample and in_now_ms. The result
// channel out_valid/out_ready carries the ten out_ fields. Configuration is
// written through cfg_we, cfg_index and cfg_wdata while the block is idle.
//
// out_valid rises once the result loads, after the capture and per-sample
// update, a legal division when a legal window ends and a duty close-out
// when the duty window ends. The shared divider does each average as a clip
// check, then twelve quotient bit steps unless it clips. The next request
// is taken in the cycle after the result loads.
//
// Reset (rst_n low at a clock edge) loads the register defaults and sets all
// window state to its reset values. A result waits in the output register
// while out_ready is low; the next request is still taken and worked on, and
// its result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_level_window_stats #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned SUM_BITS   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [15:0]                      in_sample,
  input  wire logic [31:0]                      in_now_ms,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_accepted,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_noise_average,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_legal_average,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_legal_maximum,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_peak_level,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_minimum_level,
  output logic [nlws_pkg::LEVEL_W-1:0]          out_low_level,
  output logic [nlws_pkg::DUTY_W-1:0]           out_duty_level,
  output logic                                  out_legal_window_end,
  output logic                                  out_duty_window_end,
  input  wire logic                             cfg_we,
  input  wire logic [nlws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nlws_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nlws_pkg::*;

  nlws_cmd_t cmd;
  nlws_sts_t sts;

  // Controller.
  nlws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  nlws_dp #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_sample            (in_sample),
    .in_now_ms            (in_now_ms),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_accepted         (out_accepted),
    .out_noise_average    (out_noise_average),
    .out_legal_average    (out_legal_average),
    .out_legal_maximum    (out_legal_maximum),
    .out_peak_level       (out_peak_level),
    .out_minimum_level    (out_minimum_level),
    .out_low_level        (out_low_level),
    .out_duty_level       (out_duty_level),
    .out_legal_window_end (out_legal_window_end),
    .out_duty_window_end  (out_duty_window_end)
  );

endmodule

`default_nettype wire
